// File: hw/rtl/csrsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csrsr_pkg;

  // Item kinds, also used as back-end command codes
  localparam logic [1:0] OP_LOAD_X   = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS = 2'd1;
  localparam logic [1:0] OP_MATRIX   = 2'd2;
  localparam logic [1:0] OP_END_ROW  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_BLK_EDGE     = 1'b0;
  localparam logic CFG_PRODUCT_ONLY = 1'b1;

  // Scalar position: block index times block size plus sub index, up to 4095*3+2
  localparam int POS_W = 14;
  // Widest store address and widest depth compare
  localparam int ADDR_MAX_W = 16;
  localparam int CMP_W      = 17;

  // Command queue depth
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic             oob;
    logic [31:0]      value;
    logic [1:0]       sub_row;
  } cmd_t;

  typedef struct packed {
    logic [1:0] blk_edge;
    logic       product_only;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/csrsr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module csrsr_front import csrsr_pkg::*; #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_index,
  input  wire logic [31:0] in_value,
  input  wire logic [1:0]  in_sub_row,
  input  wire logic [1:0]  in_sub_col,
  input  wire cfg_t        cfg,
  input  wire logic        q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(VECTOR_DEPTH);

  logic [POS_W-1:0] base;
  logic [POS_W-1:0] xpos;
  logic             load_oob;
  logic             elem_off;
  logic             keep;

  // Block index times block size
  assign base = POS_W'({2'b00, in_index}) * POS_W'({12'b0, cfg.blk_edge});
  assign xpos = base + POS_W'(in_sub_col);

  assign load_oob = {5'b0, in_index} >= DEPTH_C;
  assign elem_off = (in_sub_row >= cfg.blk_edge) || (in_sub_col >= cfg.blk_edge);

  // Classify the transaction and build its command
  always_comb begin
    q_cmd.op      = in_kind;
    q_cmd.value   = in_value;
    q_cmd.sub_row = in_sub_row;
    q_cmd.pos     = base;
    q_cmd.oob     = 1'b0;
    keep          = 1'b1;
    unique case (in_kind)
      OP_LOAD_X, OP_LOAD_RHS: begin
        q_cmd.pos = POS_W'(in_index);
        keep      = !load_oob;
      end
      OP_MATRIX: begin
        q_cmd.pos = xpos;
        q_cmd.oob = {3'b0, xpos} >= DEPTH_C;
        keep      = !elem_off;
      end
      default: begin
        q_cmd.pos = base;
      end
    endcase
  end

  // Drop transactions that have no effect
  assign in_ready = rst_n && !q_full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

`default_nettype wire

// File: hw/rtl/csrsr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module csrsr_cmd_fifo import csrsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t            slot_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;
  logic            do_push;
  logic            do_pop;

  assign full      = count_r == (PW+1)'(Q_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/csrsr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module csrsr_back import csrsr_pkg::*; #(
  parameter int VECTOR_DEPTH = 4096,
  parameter int MAX_BLOCK    = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_row_number,
  output logic [31:0]      out_result_value,
  output logic             out_last,
  output logic             out_flag
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int RW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(VECTOR_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_SUB  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic [31:0] S32_MIN = {1'b1, {31{1'b0}}};

  logic [31:0] x_mem   [VECTOR_DEPTH];
  logic [31:0] rhs_mem [VECTOR_DEPTH];

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r;
  logic [31:0]       x_q_r;
  logic [31:0]       rhs_q_r;
  logic [63:0]       prod_r;
  logic [63:0]       acc_r  [MAX_BLOCK];
  logic              flag_r [MAX_BLOCK];
  logic [1:0]        r_r;
  logic [POS_W-1:0]  row_r;
  logic [63:0]       val_r;
  logic              fl_r;
  logic [31:0]       res_r;
  logic              res_fl_r;

  logic              out_valid_r;
  logic [11:0]       out_row_r;
  logic [31:0]       out_val_r;
  logic              out_last_r;
  logic              out_flag_r;

  logic [ADDR_MAX_W-1:0] q_addr_ext;
  logic [ADDR_MAX_W-1:0] row_addr_ext;
  logic [AW-1:0]         q_addr;
  logic [AW-1:0]         row_addr;
  logic [RW-1:0]         sr_idx;
  logic [RW-1:0]         r_idx;

  logic signed [63:0] prod_nxt;
  logic [31:0]        xv;
  logic [63:0]        acc_cur;
  logic [63:0]        sum;
  logic               add_ov;
  logic               row_oob;
  logic [31:0]        rh;
  logic [63:0]        rh_q;
  logic [63:0]        acc_row;
  logic [63:0]        diff;
  logic               sub_ov;
  logic [48:0]        rnd;
  logic               rnd_sat;
  logic               last_row;
  logic               out_free;

  assign q_addr_ext   = ADDR_MAX_W'(q_cmd.pos);
  assign row_addr_ext = ADDR_MAX_W'(row_r);
  assign q_addr       = q_addr_ext[AW-1:0];
  assign row_addr     = row_addr_ext[AW-1:0];
  assign sr_idx       = cmd_r.sub_row[RW-1:0];
  assign r_idx        = r_r[RW-1:0];

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign last_row = r_r == (cfg.blk_edge - 2'd1);
  assign out_free = !out_valid_r || out_ready;

  // Multiply: out-of-range x reads as zero
  assign xv       = cmd_r.oob ? 32'd0 : x_q_r;
  assign prod_nxt = $signed(cmd_r.value) * $signed(xv);

  // Saturating accumulate
  assign acc_cur = acc_r[sr_idx];
  assign sum     = acc_cur + prod_r;
  assign add_ov  = (acc_cur[63] == prod_r[63]) && (sum[63] != acc_cur[63]);

  // Saturating rhs minus row sum
  assign row_oob = {3'b0, row_r} >= DEPTH_C;
  assign rh      = row_oob ? 32'd0 : rhs_q_r;
  assign rh_q    = {{16{rh[31]}}, rh, 16'b0};
  assign acc_row = acc_r[r_idx];
  assign diff    = rh_q - acc_row;
  assign sub_ov  = (rh_q[63] != acc_row[63]) && (diff[63] != rh_q[63]);

  // Round half up to Q16.16 and narrow
  assign rnd     = {val_r[63], val_r[63:16]} + {48'b0, val_r[15]};
  assign rnd_sat = rnd[48:31] != {18{rnd[48]}};

  // Vector stores: write on load, registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_LOAD_X) begin
      x_mem[q_addr] <= q_cmd.value;
    end
    if (q_pop && q_cmd.op == OP_MATRIX) begin
      x_q_r <= x_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_LOAD_RHS) begin
      rhs_mem[q_addr] <= q_cmd.value;
    end
    if (state_r == ST_RD) begin
      rhs_q_r <= rhs_mem[row_addr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_MATRIX:  state_nxt = ST_MUL;
            OP_END_ROW: state_nxt = ST_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_IDLE;
      ST_RD:   state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = last_row ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_SUB) begin
      if (cfg.product_only) begin
        val_r <= acc_row;
        fl_r  <= flag_r[r_idx] || row_oob;
      end else begin
        val_r <= sub_ov ? (rh_q[63] ? S64_MIN : S64_MAX) : diff;
        fl_r  <= flag_r[r_idx] || row_oob || sub_ov;
      end
    end
    if (state_r == ST_RND) begin
      res_r    <= rnd_sat ? (rnd[48] ? S32_MIN : S32_MAX) : rnd[31:0];
      res_fl_r <= fl_r || rnd_sat;
    end
  end

  // Row counter and scalar row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r   <= '0;
      row_r <= '0;
    end else if (q_pop && q_cmd.op == OP_END_ROW) begin
      r_r   <= '0;
      row_r <= q_cmd.pos;
    end else if (state_r == ST_OUT && out_free && !last_row) begin
      r_r   <= r_r + 2'd1;
      row_r <= row_r + 1'b1;
    end
  end

  // Accumulators and row flags: accumulate, clear after the last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCK; i++) begin
        acc_r[i]  <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (state_r == ST_ACC) begin
      acc_r[sr_idx]  <= add_ov ? (prod_r[63] ? S64_MIN : S64_MAX) : sum;
      flag_r[sr_idx] <= flag_r[sr_idx] || add_ov || cmd_r.oob;
    end else if (state_r == ST_OUT && out_free && last_row) begin
      for (int i = 0; i < MAX_BLOCK; i++) begin
        acc_r[i]  <= '0;
        flag_r[i] <= 1'b0;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_row_r  <= row_r[11:0];
      out_val_r  <= res_r;
      out_last_r <= last_row;
      out_flag_r <= res_fl_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_number   = out_row_r;
  assign out_result_value = out_val_r;
  assign out_last         = out_last_r;
  assign out_flag         = out_flag_r;

endmodule

`default_nettype wire

// File: hw/rtl/csr_sparse_residual_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    in_kind, in_index, in_value, in_sub_row, in_sub_col
// out      out_valid / out_ready  out_row_number, out_result_value, out_last, out_flag
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one transaction a cycle into a two-entry command queue while it has room.
// The back sequencer runs one command at a time: a load is written to its store as it is popped,
// a matrix element steps through x store read, multiply and saturating accumulate, and an end
// of block row steps through rhs store read, subtract, round and output for each result row,
// waiting in output while the output register stalls.
// Reset is synchronous; it clears control, accumulators and row flags, not the two stores.
// The output register holds a result until taken while the front keeps accepting until the queue is full.

module csr_sparse_residual_core import csrsr_pkg::*; #(
  parameter int VECTOR_DEPTH = 4096,
  parameter int MAX_BLOCK    = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_index,
  input  wire logic [31:0] in_value,
  input  wire logic [1:0]  in_sub_row,
  input  wire logic [1:0]  in_sub_col,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_row_number,
  output logic [31:0]      out_result_value,
  output logic             out_last,
  output logic             out_flag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);

  logic [1:0] blk_edge_r;
  logic       product_only_r;
  cfg_t       cfg;
  logic       q_full;
  logic       q_push;
  cmd_t       q_in;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_out;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_edge_r     <= 2'd1;
      product_only_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLK_EDGE:     blk_edge_r     <= cfg_data;
        CFG_PRODUCT_ONLY: product_only_r <= cfg_data[0];
        default:          blk_edge_r     <= blk_edge_r;
      endcase
    end
  end

  // Clamp block size to the supported range
  always_comb begin
    cfg.product_only = product_only_r;
    if (blk_edge_r == 2'd0) begin
      cfg.blk_edge = 2'd1;
    end else if (blk_edge_r > 2'(MAX_BLOCK)) begin
      cfg.blk_edge = 2'(MAX_BLOCK);
    end else begin
      cfg.blk_edge = blk_edge_r;
    end
  end

  csrsr_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_front (
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_sub_row (in_sub_row),
    .in_sub_col (in_sub_col),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  csrsr_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_out)
  );

  csrsr_back #(
    .VECTOR_DEPTH(VECTOR_DEPTH),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_cmd            (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_number   (out_row_number),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_flag         (out_flag)
  );

endmodule

`default_nettype wire
